@@ design/fpac_pkg.sv @@
`timescale 1ns / 1ps

package fpac_pkg;

    localparam int PARTITIONS   = 4;
    localparam int ENTRY_SLOTS  = 4;
    localparam int ADDR_BITS    = 24;

    localparam int ID_W         = 32;
    localparam int FLAGS_W      = 4;
    localparam int LOG2_W       = 5;
    localparam int BASE_W       = 24;
    localparam int SIZE_W       = 25;
    localparam int ATTRS_W      = 46;
    localparam int EXTENT_W     = 49;
    localparam int CFG_DATA_W   = 49;
    localparam int CFG_INDEX_W  = 3;
    localparam int SLOT_W       = 2;
    localparam int OFF_W        = 32;
    localparam int LEN_W        = 32;
    localparam int FLASH_ADDR_W = 24;

    // Attribute word layout.
    localparam int FLAG_LO      = 32;
    localparam int EB_LO        = 36;
    localparam int WU_LO        = 41;

    // Flag bits inside the attribute flags nibble.
    localparam int FLAG_READ    = 0;
    localparam int FLAG_WRITE   = 1;
    localparam int FLAG_ERASE   = 2;

    // Low bit of the register index selects the word of an entry.
    localparam logic CFG_SEL_ATTRS  = 1'b0;
    localparam logic CFG_SEL_EXTENT = 1'b1;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_ERASE = 2'd1,
        OP_WRITE = 2'd2,
        OP_FLUSH = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_DENIED    = 2'd3
    } status_t;

    typedef struct packed {
        logic               found;
        logic [BASE_W-1:0]  base;
        logic [SIZE_W-1:0]  size;
        logic [FLAGS_W-1:0] flags;
        logic [LOG2_W-1:0]  eb_log2;
        logic [LOG2_W-1:0]  wu_log2;
    } entry_t;

endpackage

@@ design/fpac_req_if.sv @@
`timescale 1ns / 1ps

interface fpac_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] part_id;
    logic [31:0] rel_offset;
    logic [31:0] length;

    modport source (output valid, output op, output part_id, output rel_offset,
                    output length, input ready);
    modport sink (input valid, input op, input part_id, input rel_offset,
                  input length, output ready);
endinterface

@@ design/fpac_rsp_if.sv @@
`timescale 1ns / 1ps

interface fpac_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [23:0] flash_addr;
    logic        issue;

    modport source (output valid, output status, output flash_addr, output issue,
                    input ready);
    modport sink (input valid, input status, input flash_addr, input issue,
                  output ready);
endinterface

@@ design/fpac_table.sv @@
`timescale 1ns / 1ps

module fpac_table
    import fpac_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [ID_W-1:0]        part_id,
    output entry_t                 hit
);

    logic [ATTRS_W-1:0]  attrs_reg  [ENTRY_SLOTS];
    logic [EXTENT_W-1:0] extent_reg [ENTRY_SLOTS];
    logic [SLOT_W-1:0]   wr_slot;

    assign wr_slot = cfg_index[CFG_INDEX_W-1:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRY_SLOTS; i++)
            begin
                attrs_reg[i]  <= '0;
                extent_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index[0] == CFG_SEL_ATTRS)
                attrs_reg[wr_slot] <= cfg_data[ATTRS_W-1:0];
            else
                extent_reg[wr_slot] <= cfg_data[EXTENT_W-1:0];
        end
    end

    // Walk from the top entry down so that the lowest matching entry wins.
    always_comb
    begin
        hit = '0;
        for (int i = PARTITIONS - 1; i >= 0; i--)
        begin
            if (extent_reg[i][BASE_W +: SIZE_W] != '0
                && attrs_reg[i][ID_W-1:0] == part_id)
            begin
                hit.found   = 1'b1;
                hit.base    = extent_reg[i][BASE_W-1:0];
                hit.size    = extent_reg[i][BASE_W +: SIZE_W];
                hit.flags   = attrs_reg[i][FLAG_LO +: FLAGS_W];
                hit.eb_log2 = attrs_reg[i][EB_LO +: LOG2_W];
                hit.wu_log2 = attrs_reg[i][WU_LO +: LOG2_W];
            end
        end
    end

endmodule

@@ design/flash_partition_access_check_top.sv @@
`timescale 1ns / 1ps

// Checks flash access requests against a four-entry partition table that is
// written through the cfg port, and returns one response per request with the
// status, the absolute flash address and the issue flag. The datapath is a
// three-stage pipeline (table lookup, permission/alignment/partition range,
// device range and result), and a new request can be taken in every cycle
// while responses are accepted; a stalled response holds the pipeline
// without losing or repeating anything. The table should only be written
// while no request is in flight.

module flash_partition_access_check_top
    import fpac_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    fpac_req_if.sink               req,
    fpac_rsp_if.source             rsp
);

    localparam logic [LEN_W+1:0] ADDR_SPAN = (LEN_W+2)'(1) << ADDR_BITS;

    entry_t hit;

    // Stage 1: lookup result and request.
    logic              s1_valid_reg;
    op_t               s1_op_reg;
    logic [OFF_W-1:0]  s1_off_reg;
    logic [LEN_W-1:0]  s1_len_reg;
    entry_t            s1_entry_reg;

    // Stage 2: early status and partial sums.
    logic              s2_valid_reg;
    status_t           s2_status_reg;
    logic              s2_pending_reg;
    logic              s2_flush_reg;
    logic [OFF_W:0]    s2_addr_reg;
    logic [LEN_W-1:0]  s2_len_reg;

    // Stage 3: response register.
    logic                    s3_valid_reg;
    status_t                 s3_status_reg;
    logic [FLASH_ADDR_W-1:0] s3_addr_reg;
    logic                    s3_issue_reg;

    logic s1_ready, s2_ready, s3_ready;

    fpac_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .part_id   (req.part_id),
        .hit       (hit)
    );

    assign s3_ready  = !s3_valid_reg || rsp.ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req.ready = s1_ready;

    // Stage 2 logic.
    logic [OFF_W-1:0] eb_mask, wu_mask, off_or_len;
    logic [OFF_W:0]   rel_end;
    logic             denied, misaligned, out_of_part;
    status_t          s2_status_next;
    logic             s2_pending_next;

    always_comb
    begin
        eb_mask     = ~({OFF_W{1'b1}} << s1_entry_reg.eb_log2);
        wu_mask     = ~({OFF_W{1'b1}} << s1_entry_reg.wu_log2);
        off_or_len  = s1_off_reg | s1_len_reg;
        rel_end     = {1'b0, s1_off_reg} + {1'b0, s1_len_reg};
        out_of_part = rel_end > (OFF_W+1)'(s1_entry_reg.size);
        denied      = 1'b0;
        misaligned  = 1'b0;
        unique case (s1_op_reg)
            OP_READ:  denied = !s1_entry_reg.flags[FLAG_READ];
            OP_ERASE:
            begin
                denied     = !s1_entry_reg.flags[FLAG_ERASE];
                misaligned = (off_or_len & eb_mask) != '0;
            end
            OP_WRITE:
            begin
                denied     = !s1_entry_reg.flags[FLAG_WRITE];
                misaligned = (off_or_len & wu_mask) != '0;
            end
            OP_FLUSH: denied = 1'b0;
            default:  denied = 1'b0;
        endcase

        s2_pending_next = 1'b0;
        priority if (!s1_entry_reg.found)
            s2_status_next = ST_NOT_FOUND;
        else if (s1_op_reg == OP_FLUSH)
            s2_status_next = ST_OK;
        else if (denied)
            s2_status_next = ST_DENIED;
        else if (misaligned || out_of_part)
            s2_status_next = ST_INVALID;
        else
        begin
            // Still subject to the device range check in stage 3.
            s2_status_next  = ST_OK;
            s2_pending_next = 1'b1;
        end
    end

    // Stage 3 logic.
    logic [LEN_W+1:0] abs_end;
    logic             past_device;
    status_t          s3_status_next;
    logic             s3_ok;

    always_comb
    begin
        abs_end        = {1'b0, s2_addr_reg} + (LEN_W+2)'(s2_len_reg);
        past_device    = abs_end > ADDR_SPAN;
        s3_status_next = (s2_pending_reg && past_device) ? ST_INVALID : s2_status_reg;
        s3_ok          = s2_pending_reg && !past_device;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= req.valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && req.valid)
        begin
            s1_op_reg    <= op_t'(req.op);
            s1_off_reg   <= req.rel_offset;
            s1_len_reg   <= req.length;
            s1_entry_reg <= hit;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_status_reg  <= s2_status_next;
            s2_pending_reg <= s2_pending_next;
            s2_flush_reg   <= s1_op_reg == OP_FLUSH;
            s2_addr_reg    <= (OFF_W+1)'(s1_entry_reg.base) + {1'b0, s1_off_reg};
            s2_len_reg     <= s1_len_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_status_reg <= s3_status_next;
            s3_addr_reg   <= s3_ok ? s2_addr_reg[FLASH_ADDR_W-1:0] : '0;
            s3_issue_reg  <= s3_ok && !s2_flush_reg && (s2_len_reg != '0);
        end
    end

    assign rsp.valid      = s3_valid_reg;
    assign rsp.status     = s3_status_reg;
    assign rsp.flash_addr = s3_addr_reg;
    assign rsp.issue      = s3_issue_reg;

endmodule
